FILE: rtl/dlv_pkg.sv
package dlv_pkg;

    localparam int DLV_MAX_VALUES = 512;

    localparam int         ARG_COUNT_W   = 10;
    localparam logic [9:0] ARG_COUNT_MAX = 10'd1023;

    // magnitude clamps here; also the most negative int32
    localparam logic [31:0] LIMIT_MAG = 32'h8000_0000;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        MODE_CHAR     = 2'd0,
        MODE_END_ARG  = 2'd1,
        MODE_END_LIST = 2'd2,
        MODE_NOP      = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_FORMAT = 3'd1,
        ERR_RANGE  = 3'd2,
        ERR_DUP    = 3'd3,
        ERR_FULL   = 3'd4
    } err_t;

    typedef struct packed {
        logic take_char;
        logic end_arg;
        logic rd_en;
        logic wr_en;
        logic report;
    } dlv_cmd_t;

    typedef struct packed {
        logic arg_ok;     // argument being ended is well formed and in range
        logic pending;    // characters seen since the last argument end
        logic skip_scan;  // table empty or duplicate already known
        logic last_rd;    // scan index is at the last stored entry
        logic out_free;   // result register can take a new beat
    } dlv_status_t;

endpackage

FILE: rtl/dlv_ctrl.sv
module dlv_ctrl
    import dlv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic [1:0]  s_mode,
    output logic        s_ready,
    input  dlv_status_t status,
    output dlv_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WRITE  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   report_pend_reg, report_pend_next;
    logic   accept;
    mode_t  mode;

    assign mode    = mode_t'(s_mode);
    // a list end waits until the result register is free
    assign s_ready = (state_reg == ST_IDLE) && ((mode != MODE_END_LIST) || status.out_free);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next       = state_reg;
        report_pend_next = report_pend_reg;
        cmd              = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (mode)
                        MODE_CHAR: begin
                            cmd.take_char = 1'b1;
                        end
                        MODE_END_ARG: begin
                            cmd.end_arg = 1'b1;
                            if (status.arg_ok) begin
                                state_next = status.skip_scan ? ST_WRITE : ST_SCAN;
                            end
                        end
                        MODE_END_LIST: begin
                            if (status.pending) begin
                                // implicit argument end before the report
                                cmd.end_arg      = 1'b1;
                                report_pend_next = 1'b1;
                                if (status.arg_ok) begin
                                    state_next = status.skip_scan ? ST_WRITE : ST_SCAN;
                                end else begin
                                    state_next = ST_REPORT;
                                end
                            end else begin
                                cmd.report = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.rd_en = 1'b1;
                if (status.last_rd) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                cmd.wr_en  = 1'b1;
                state_next = report_pend_reg ? ST_REPORT : ST_IDLE;
            end
            ST_REPORT: begin
                cmd.report       = 1'b1;
                report_pend_next = 1'b0;
                state_next       = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            report_pend_reg <= 1'b0;
        end else begin
            state_reg       <= state_next;
            report_pend_reg <= report_pend_next;
        end
    end

    a_scan_needs_entries: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && cmd.end_arg && status.arg_ok && !status.skip_scan
        |=> (state_reg == ST_SCAN))
        else $error("argument end did not start a table scan");

    a_report_after_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) && report_pend_reg |=> (state_reg == ST_REPORT))
        else $error("list end lost after table write");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !cmd.take_char && !cmd.end_arg)
        else $error("token command issued while busy");

endmodule

FILE: rtl/dlv_datapath.sv
module dlv_datapath
    import dlv_pkg::*;
#(
    parameter int MAX_VALUES = DLV_MAX_VALUES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic [7:0]             s_ch,
    input  logic                   m_ready,
    input  dlv_cmd_t               cmd,
    output dlv_status_t            status,
    output logic                   m_valid,
    output logic                   m_valid_res,
    output logic [2:0]             m_error_code,
    output logic [ARG_COUNT_W-1:0] m_count
);

    localparam int AW = $clog2(MAX_VALUES);
    localparam int CW = $clog2(MAX_VALUES + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_VALUES);

    logic [31:0] mem [MAX_VALUES];

    logic [31:0]            magnitude_reg;
    logic                   negative_reg;
    logic [1:0]             char_pos_reg;
    logic                   digit_seen_reg;
    err_t                   token_err_reg;
    err_t                   first_err_reg;
    logic                   dup_reg;
    logic                   full_reg;
    logic [ARG_COUNT_W-1:0] arg_count_reg;
    logic [CW-1:0]          stored_count_reg;
    logic [AW-1:0]          scan_idx_reg;
    logic                   rd_valid_reg;
    logic [31:0]            rd_data_reg;
    logic [31:0]            value_reg;

    logic                   m_valid_reg;
    logic                   m_valid_res_reg;
    err_t                   m_error_code_reg;
    logic [ARG_COUNT_W-1:0] m_count_reg;

    logic        is_digit;
    logic [3:0]  digit;
    logic [35:0] mag_sum;
    logic        mag_over;
    err_t        arg_err;
    logic [31:0] arg_value;
    logic        hit;
    err_t        list_code;

    assign is_digit  = (s_ch >= CH_ZERO) && (s_ch <= CH_NINE);
    assign digit     = s_ch[3:0];
    // magnitude * 10 + digit as two shifts and adds
    assign mag_sum   = {1'b0, magnitude_reg, 3'b000} + {3'b000, magnitude_reg, 1'b0}
                     + {32'd0, digit};
    assign mag_over  = mag_sum > {4'd0, LIMIT_MAG};
    assign arg_value = negative_reg ? (32'd0 - magnitude_reg) : magnitude_reg;

    always_comb begin
        arg_err = token_err_reg;
        if (!digit_seen_reg) begin
            arg_err = ERR_FORMAT;
        end else if ((token_err_reg == ERR_NONE) && !negative_reg
                     && (magnitude_reg > (LIMIT_MAG - 32'd1))) begin
            arg_err = ERR_RANGE;
        end
    end

    always_comb begin
        if (first_err_reg != ERR_NONE) begin
            list_code = first_err_reg;
        end else if (dup_reg) begin
            list_code = ERR_DUP;
        end else if (full_reg) begin
            list_code = ERR_FULL;
        end else begin
            list_code = ERR_NONE;
        end
    end

    assign hit = rd_valid_reg && (rd_data_reg == value_reg);

    assign status.arg_ok    = (arg_err == ERR_NONE);
    assign status.pending   = (char_pos_reg != 2'd0);
    assign status.skip_scan = dup_reg || (stored_count_reg == '0);
    assign status.last_rd   = ((CW'(scan_idx_reg) + CW'(1)) == stored_count_reg);
    assign status.out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magnitude_reg    <= '0;
            negative_reg     <= 1'b0;
            char_pos_reg     <= '0;
            digit_seen_reg   <= 1'b0;
            token_err_reg    <= ERR_NONE;
            first_err_reg    <= ERR_NONE;
            dup_reg          <= 1'b0;
            full_reg         <= 1'b0;
            arg_count_reg    <= '0;
            stored_count_reg <= '0;
            scan_idx_reg     <= '0;
            rd_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.report) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cmd.take_char) begin
                if ((char_pos_reg == 2'd0) && (s_ch == CH_MINUS)) begin
                    negative_reg <= 1'b1;
                end else if (is_digit) begin
                    digit_seen_reg <= 1'b1;
                    if (mag_over) begin
                        magnitude_reg <= LIMIT_MAG;
                        if (token_err_reg == ERR_NONE) begin
                            token_err_reg <= ERR_RANGE;
                        end
                    end else begin
                        magnitude_reg <= mag_sum[31:0];
                    end
                end else begin
                    // format wins over an earlier range error
                    token_err_reg <= ERR_FORMAT;
                end
                if (char_pos_reg != 2'd2) begin
                    char_pos_reg <= char_pos_reg + 2'd1;
                end
            end

            if (cmd.end_arg) begin
                if (arg_count_reg != ARG_COUNT_MAX) begin
                    arg_count_reg <= arg_count_reg + 1'b1;
                end
                if ((arg_err != ERR_NONE) && (first_err_reg == ERR_NONE)) begin
                    first_err_reg <= arg_err;
                end
                scan_idx_reg   <= '0;
                magnitude_reg  <= '0;
                negative_reg   <= 1'b0;
                char_pos_reg   <= '0;
                digit_seen_reg <= 1'b0;
                token_err_reg  <= ERR_NONE;
            end

            if (cmd.rd_en) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
            if (hit) begin
                dup_reg <= 1'b1;
            end

            if (cmd.wr_en) begin
                if (stored_count_reg < MAX_CNT) begin
                    stored_count_reg <= stored_count_reg + 1'b1;
                end else begin
                    full_reg <= 1'b1;
                end
            end

            if (cmd.report) begin
                first_err_reg    <= ERR_NONE;
                dup_reg          <= 1'b0;
                full_reg         <= 1'b0;
                arg_count_reg    <= '0;
                stored_count_reg <= '0;
            end
        end
    end

    // result payload and the value under test
    always_ff @(posedge aclk) begin
        if (cmd.end_arg) begin
            value_reg <= arg_value;
        end
        if (cmd.report) begin
            m_valid_res_reg  <= (list_code == ERR_NONE);
            m_error_code_reg <= list_code;
            m_count_reg      <= arg_count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && (stored_count_reg < MAX_CNT)) begin
            mem[stored_count_reg[AW-1:0]] <= value_reg;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = m_valid_res_reg;
    assign m_error_code = m_error_code_reg;
    assign m_count      = m_count_reg;

    a_rd_written: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (CW'(scan_idx_reg) < stored_count_reg))
        else $error("table read beyond stored entries");

    a_report_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.report |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stored_count_reg <= MAX_CNT)
        else $error("stored count beyond table size");

    a_mag_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        magnitude_reg <= LIMIT_MAG)
        else $error("magnitude above clamp");

endmodule

FILE: rtl/decimal_list_validator.sv
// Channel  Handshake          Payload
// s_       s_valid/s_ready    s_mode[1:0], s_ch[7:0]
// m_       m_valid/m_ready    m_valid_res, m_error_code[2:0], m_count[9:0]
//
// A character beat is absorbed when accepted. An argument end scans the table when the
// argument is well formed (over the stored entries, skipped when none are stored or a
// duplicate is known; the table memory has one read port, scanned one entry per cycle), then one write.
// A list end with an open argument ends that argument first, then issues the report.
// Reset is synchronous, active low; no clearing pass, the stored count bounds reads.
// A list end is held off while an earlier result has not been taken; other beats are not.
module decimal_list_validator
    import dlv_pkg::*;
#(
    parameter int MAX_VALUES = DLV_MAX_VALUES
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_mode,
    input  logic [7:0]             s_ch,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_valid_res,
    output logic [2:0]             m_error_code,
    output logic [ARG_COUNT_W-1:0] m_count
);

    dlv_cmd_t    cmd;
    dlv_status_t status;

    dlv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dlv_datapath #(
        .MAX_VALUES (MAX_VALUES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_ch         (s_ch),
        .m_ready      (m_ready),
        .cmd          (cmd),
        .status       (status),
        .m_valid      (m_valid),
        .m_valid_res  (m_valid_res),
        .m_error_code (m_error_code),
        .m_count      (m_count)
    );

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dlv_pkg::*;

    localparam int RANDOM_BEATS = 1300;
    localparam int RANDOM_LISTS = 40;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 20;

    typedef logic [7:0] char_q_t[$];

    typedef struct {
        logic                   valid_res;
        err_t                   code;
        logic [ARG_COUNT_W-1:0] count;
    } list_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [1:0]             s_mode;
    logic [7:0]             s_ch;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_valid_res;
    logic [2:0]             m_error_code;
    logic [ARG_COUNT_W-1:0] m_count;

    decimal_list_validator dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_ch        (s_ch),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_error_code(m_error_code),
        .m_count     (m_count)
    );

    // list parser state, mirrored
    logic [31:0]            mag;
    bit                     neg;
    logic [1:0]             cpos;
    bit                     dseen;
    err_t                   tok_err;
    err_t                   first_err;
    bit                     dup_seen;
    bit                     full_seen;
    logic [ARG_COUNT_W-1:0] n_args;
    logic [31:0]            stored[$];

    list_report_t reports_due[$];
    int           mismatches;
    int           beats_sent;
    bit           calm;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_token();
        mag = '0;
        neg = 1'b0;
        cpos = '0;
        dseen = 1'b0;
        tok_err = ERR_NONE;
    endfunction

    function automatic void clear_list();
        clear_token();
        first_err = ERR_NONE;
        dup_seen = 1'b0;
        full_seen = 1'b0;
        n_args = '0;
        stored.delete();
    endfunction

    function automatic void absorb_char(logic [7:0] c);
        logic [63:0] next;
        if (cpos == 0 && c == CH_MINUS) begin
            neg = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            next = {32'd0, mag} * 64'd10 + {56'd0, c - CH_ZERO};
            dseen = 1'b1;
            if (next > {32'd0, LIMIT_MAG}) begin
                next = {32'd0, LIMIT_MAG};
                if (tok_err == ERR_NONE) tok_err = ERR_RANGE;
            end
            mag = next[31:0];
        end else begin
            tok_err = ERR_FORMAT;
        end
        if (cpos < 2) cpos = cpos + 2'd1;
    endfunction

    function automatic void close_argument();
        err_t        err;
        logic [31:0] v;
        err = tok_err;
        if (!dseen) err = ERR_FORMAT;
        // -2^31 is the only clamped magnitude that still fits
        if (err == ERR_NONE && !neg && mag > LIMIT_MAG - 32'd1) err = ERR_RANGE;
        if (n_args < ARG_COUNT_MAX) n_args = n_args + 1'b1;
        if (err != ERR_NONE) begin
            if (first_err == ERR_NONE) first_err = err;
        end else begin
            v = neg ? 32'd0 - mag : mag;
            foreach (stored[i]) begin
                if (stored[i] == v) dup_seen = 1'b1;
            end
            if (stored.size() < DLV_MAX_VALUES) stored.push_back(v);
            else full_seen = 1'b1;
        end
        clear_token();
    endfunction

    function automatic void close_list();
        list_report_t r;
        if (cpos != 0) close_argument();
        if (first_err != ERR_NONE) r.code = first_err;
        else if (dup_seen) r.code = ERR_DUP;
        else if (full_seen) r.code = ERR_FULL;
        else r.code = ERR_NONE;
        r.valid_res = (r.code == ERR_NONE);
        r.count = n_args;
        reports_due.push_back(r);
        clear_list();
    endfunction

    function automatic void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    function automatic void check_report();
        list_report_t want;
        if (reports_due.size() == 0) begin
            note_mismatch($sformatf("%0t: unexpected report valid=%0b code=%0d count=%0d",
                $time, m_valid_res, m_error_code, m_count));
            return;
        end
        want = reports_due.pop_front();
        if (m_valid_res !== want.valid_res || m_error_code !== want.code ||
            m_count !== want.count) begin
            note_mismatch($sformatf(
                "%0t: report mismatch exp valid=%0b code=%0d count=%0d, got %0b %0d %0d",
                $time, want.valid_res, want.code, want.count,
                m_valid_res, m_error_code, m_count));
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) check_report();
            if (s_valid && s_ready) begin
                case (s_mode)
                    MODE_CHAR:     absorb_char(s_ch);
                    MODE_END_ARG:  close_argument();
                    MODE_END_LIST: close_list();
                    default: ;
                endcase
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    // result side back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_left == 0) stall_left = pick_gap();
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // entered and left at a falling edge; valid stays up between back-to-back beats
    task automatic send_beat(mode_t m, logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= m;
        s_ch <= c;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (m != MODE_NOP) beats_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_beat(MODE_CHAR, s[i]);
    endtask

    task automatic send_arg_str(string s);
        send_text(s);
        send_beat(MODE_END_ARG, 8'($urandom_range(0, 255)));
    endtask

    task automatic end_list();
        send_beat(MODE_END_LIST, 8'($urandom_range(0, 255)));
    endtask

    function automatic char_q_t make_arg();
        char_q_t           q;
        int                r;
        int                n;
        string             s;
        logic [7:0]        junk;
        longint unsigned   v;
        longint unsigned   bounds[6];
        bounds = '{64'd2147483647, 64'd2147483648, 64'd2147483649,
                   64'd4294967295, 64'd0, 64'd214748364};
        r = $urandom_range(0, 99);
        if (r < 7) return q;
        if (r < 11) begin
            q.push_back(CH_MINUS);
            return q;
        end
        if ($urandom_range(0, 2) == 0) q.push_back(CH_MINUS);
        case ($urandom_range(0, 4))
            0: v = $urandom_range(0, 12);
            1: v = $urandom();
            2: v = bounds[$urandom_range(0, 5)];
            3: v = 64'd0;
            default: v = $urandom_range(0, 99);
        endcase
        if (q.size() == 0 || $urandom_range(0, 1) == 0) begin
            // leading zeros now and then
            repeat ($urandom_range(0, 1) * $urandom_range(1, 3)) q.push_back(CH_ZERO);
        end
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        if ($urandom_range(0, 7) == 0) begin
            // long digit run, can clamp the magnitude
            n = $urandom_range(4, 10);
            repeat (n) q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if (r < 28) begin
            do junk = 8'($urandom_range(0, 255)); while (junk >= CH_ZERO && junk <= CH_NINE);
            q.insert($urandom_range(0, q.size()), junk);
        end
        return q;
    endfunction

    task automatic test_empty_and_nop();
        end_list();
        send_beat(MODE_NOP, 8'hFF);
        send_arg_str("7");
        send_beat(MODE_NOP, CH_ZERO);
        send_text("-3");
        end_list();
    endtask

    task automatic test_format_errors();
        send_arg_str("");
        send_arg_str("-");
        end_list();
        send_arg_str("1-2");
        send_arg_str("--5");
        end_list();
        send_arg_str("0");
        send_arg_str("-0");
        end_list();
        // format outranks a duplicate seen earlier
        send_arg_str("3");
        send_arg_str("3");
        send_arg_str("x");
        end_list();
        send_arg_str("99999999999");
        send_arg_str("x");
        end_list();
        send_text("-");
        end_list();
    endtask

    task automatic test_int32_bounds();
        send_arg_str("2147483647");
        send_arg_str("-2147483648");
        end_list();
        send_arg_str("12345678901234567x");
        end_list();
    endtask

    task automatic test_table_full();
        for (int i = 0; i < DLV_MAX_VALUES; i++) send_arg_str($sformatf("%0d", i));
        // not stored once full, so the repeat is no duplicate
        send_arg_str("1000");
        send_arg_str("1000");
        end_list();
    endtask

    task automatic test_count_saturation();
        calm = 1'b1;
        repeat (int'(ARG_COUNT_MAX) + 8) send_beat(MODE_END_ARG, 8'($urandom_range(0, 255)));
        end_list();
        calm = 1'b0;
    endtask

    task automatic test_random_lists();
        int      target;
        int      lists_done;
        int      n_list_args;
        char_q_t arg;
        target = beats_sent + RANDOM_BEATS;
        lists_done = 0;
        while (beats_sent < target || lists_done < RANDOM_LISTS) begin
            calm = ($urandom_range(0, 4) == 0);
            n_list_args = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
            for (int a = 0; a < n_list_args; a++) begin
                arg = make_arg();
                foreach (arg[i]) begin
                    if ($urandom_range(0, 19) == 0)
                        send_beat(MODE_NOP, 8'($urandom_range(0, 255)));
                    send_beat(MODE_CHAR, arg[i]);
                end
                // last argument sometimes left open for the list end to close
                if (a != n_list_args - 1 || $urandom_range(0, 2) != 0)
                    send_beat(MODE_END_ARG, 8'($urandom_range(0, 255)));
            end
            end_list();
            lists_done++;
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_NOP;
        s_ch = '0;
        calm = 1'b0;
        mismatches = 0;
        beats_sent = 0;
        clear_list();
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_and_nop();
        test_format_errors();
        test_int32_bounds();
        test_table_full();
        test_count_saturation();
        test_random_lists();

        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
